>>> sv/tct_pkg.sv
package tct_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS = 32;
    localparam int DATA_W = 32;
    localparam int ID_W = 8;

    typedef enum logic [2:0] {
        CMD_ADVANCE   = 3'd0,
        CMD_SEEK      = 3'd1,
        CMD_ADD       = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_REMOVE_RG = 3'd4,
        CMD_CLEAR     = 3'd5,
        CMD_QUERY     = 3'd6,
        CMD_NONE      = 3'd7
    } cmd_t;

    localparam logic [0:0] REG_AUTO_REMOVE = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and restart the scan
        logic scan_step;  // advance the table scan
        logic move_step;  // advance the insert or erase sweep
        logic emit_step;  // advance the emit index
        logic fill_upd;   // update the fill count
        logic play_upd;   // update the playhead
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic move_done;
        logic emit_done;
        logic emit_any;
    } dp_stat_t;

endpackage

>>> sv/tct_if.sv
interface tct_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [31:0] time_a;
    logic signed [31:0] time_b;
    logic [7:0]  cue_id;
    modport source (output valid, command, time_a, time_b, cue_id, input ready);
    modport sink (input valid, command, time_a, time_b, cue_id, output ready);
endinterface

interface tct_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [7:0]  hit_id;
    logic signed [31:0] hit_time;
    logic        status;
    logic        last;
    modport source (output valid, hit, hit_id, hit_time, status, last, input ready);
    modport sink (input valid, hit, hit_id, hit_time, status, last, output ready);
endinterface

>>> sv/tct_ram.sv
module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/tct_ctrl.sv
module tct_ctrl import tct_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_cmd,
    input  logic       auto_remove,
    input  logic       full,
    input  logic       rev_range,
    input  logic       out_ready,
    output logic       out_valid,
    output logic       out_hit,
    output logic       out_status,
    output logic       out_last,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EMIT = 6'b000100,
        S_WAIT = 6'b001000,
        S_MOVE = 6'b010000,
        S_ACK  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_NONE;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_hit     = 1'b0;
        out_status  = 1'b0;
        out_last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd_next    = cmd_t'(in_cmd);
                    status_next = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    unique case (cmd_reg)
                        CMD_ADVANCE:
                            state_next = stat.emit_any ? S_EMIT : S_ACK;
                        CMD_QUERY:
                            state_next = (!rev_range && stat.emit_any) ? S_EMIT : S_ACK;
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                status_next = 1'b1;
                                state_next  = S_ACK;
                            end
                            else
                            begin
                                state_next = S_MOVE;
                            end
                        end
                        CMD_REMOVE_AT:
                            state_next = S_MOVE;
                        CMD_REMOVE_RG:
                            state_next = rev_range ? S_ACK : S_MOVE;
                        default:
                            state_next = S_ACK;
                    endcase
                end
            end
            S_EMIT:
            begin
                // The read issued here returns next cycle.
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                out_valid = 1'b1;
                out_hit   = 1'b1;
                out_last  = stat.emit_done;
                if (out_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (!stat.emit_done)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (cmd_reg == CMD_ADVANCE && auto_remove)
                    begin
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        cmd.play_upd = (cmd_reg == CMD_ADVANCE);
                        state_next   = S_IDLE;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move_step = 1'b1;
                if (stat.move_done)
                begin
                    cmd.fill_upd = 1'b1;
                    if (cmd_reg == CMD_ADVANCE)
                    begin
                        cmd.play_upd = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_ACK:
            begin
                out_valid  = 1'b1;
                out_status = status_reg;
                if (out_ready)
                begin
                    cmd.play_upd = (cmd_reg inside {CMD_ADVANCE, CMD_SEEK});
                    cmd.fill_upd = (cmd_reg == CMD_CLEAR);
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

>>> sv/tct_dp.sv
module tct_dp import tct_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               in_cmd,
    input  logic signed [DATA_W-1:0] in_a,
    input  logic signed [DATA_W-1:0] in_b,
    input  logic [ID_W-1:0]          in_id,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    output logic                     full,
    output logic                     rev_range,
    output logic [ID_W-1:0]          hit_id,
    output logic signed [DATA_W-1:0] hit_time
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RD = (CAPACITY > 1) ? CAPACITY : 2;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] MAXR = (CAPACITY < MAX_RESULTS) ? CAP : CW'(MAX_RESULTS);

    localparam logic [1:0] MPH_READ  = 2'd0;
    localparam logic [1:0] MPH_WRITE = 2'd1;
    localparam logic [1:0] MPH_NEW   = 2'd2;

    logic [CW-1:0] fill_reg, fill_next;
    logic signed [DATA_W-1:0] play_reg, pl_next_reg;
    cmd_t c_reg;
    logic signed [DATA_W-1:0] ins_t_reg, lo_t_reg, hi_t_reg;
    logic [ID_W-1:0] id_reg;
    logic rev_reg;
    logic pend_reg;
    logic [CW-1:0] idx_reg, lo_reg, hi_reg, emit_reg, mv_reg;
    logic [CW-1:0] emit_plus;
    logic [1:0] mph_reg;
    logic [32:0] step;
    logic [32:0] sum;
    logic signed [DATA_W-1:0] sat;
    logic ins;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [DATA_W-1:0] wt, rt;
    logic [ID_W-1:0] wi, ri;

    tct_ram #(.WIDTH(DATA_W), .DEPTH(RD)) u_time (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wt), .raddr(raddr), .rdata(rt));
    tct_ram #(.WIDTH(ID_W), .DEPTH(RD)) u_id (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wi), .raddr(raddr), .rdata(ri));

    // A negative step counts as zero; the end of the window saturates.
    assign step = in_a[31] ? 33'd0 : {1'b0, in_a};
    assign sum = {play_reg[31], play_reg} + step;
    assign sat = (!sum[32] && sum[31]) ? 32'sh7fffffff : sum[31:0];

    assign full = (fill_reg >= CAP);
    assign rev_range = rev_reg;
    assign hit_id = ri;
    assign hit_time = rt;
    assign ins = (c_reg == CMD_ADD);
    assign emit_plus = emit_reg + CW'(1);

    always_comb
    begin
        stat.scan_done = !pend_reg && (idx_reg >= fill_reg);
        stat.emit_any  = (hi_reg > lo_reg);
        stat.emit_done = (emit_plus >= hi_reg) || ((emit_plus - lo_reg) >= MAXR);
        stat.move_done = ins ? (mph_reg == MPH_NEW)
                             : (mph_reg == MPH_READ && mv_reg >= fill_reg);
    end

    // Insert shifts entries fill-1 down to hi up by one, then writes the new
    // cue at hi. Erase copies entries hi..fill-1 down to lo.
    always_comb
    begin
        raddr = emit_reg[AW-1:0];
        if (cmd.scan_step)
        begin
            raddr = idx_reg[AW-1:0];
        end
        if (cmd.move_step)
        begin
            raddr = mv_reg[AW-1:0];
        end
        we    = 1'b0;
        waddr = '0;
        wt    = rt;
        wi    = ri;
        if (cmd.move_step)
        begin
            if (ins)
            begin
                if (mph_reg == MPH_WRITE)
                begin
                    we    = 1'b1;
                    waddr = AW'(mv_reg + CW'(1));
                end
                else if (mph_reg == MPH_NEW)
                begin
                    we    = 1'b1;
                    waddr = hi_reg[AW-1:0];
                    wt    = ins_t_reg;
                    wi    = id_reg;
                end
            end
            else if (mph_reg == MPH_WRITE)
            begin
                we    = 1'b1;
                waddr = AW'(mv_reg - hi_reg + lo_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            play_reg    <= '0;
            pl_next_reg <= '0;
            c_reg       <= CMD_NONE;
            ins_t_reg   <= '0;
            id_reg      <= '0;
            rev_reg     <= 1'b0;
            lo_t_reg    <= '0;
            hi_t_reg    <= '0;
            pend_reg    <= 1'b0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            emit_reg    <= '0;
            mv_reg      <= '0;
            mph_reg     <= MPH_READ;
        end
        else
        begin
            if (cmd.load)
            begin
                c_reg     <= cmd_t'(in_cmd);
                ins_t_reg <= in_a;
                id_reg    <= in_id;
                rev_reg   <= (in_b < in_a);
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                lo_reg    <= '0;
                hi_reg    <= '0;
                unique case (cmd_t'(in_cmd)) inside
                    CMD_ADVANCE:
                    begin
                        lo_t_reg    <= play_reg;
                        hi_t_reg    <= sat;
                        pl_next_reg <= sat;
                    end
                    CMD_REMOVE_RG, CMD_QUERY:
                    begin
                        lo_t_reg    <= in_a;
                        hi_t_reg    <= in_b;
                        pl_next_reg <= in_a;
                    end
                    default:
                    begin
                        lo_t_reg    <= in_a;
                        hi_t_reg    <= in_a;
                        pl_next_reg <= in_a;
                    end
                endcase
            end
            if (cmd.scan_step)
            begin
                // Reads are issued one per cycle; the compare takes the registered read data, flagged by pend_reg.
                if (idx_reg < fill_reg)
                begin
                    idx_reg  <= idx_reg + CW'(1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg)
                begin
                    if (rt < lo_t_reg)
                    begin
                        lo_reg <= lo_reg + CW'(1);
                    end
                    if (rt <= hi_t_reg)
                    begin
                        hi_reg <= hi_reg + CW'(1);
                    end
                end
                if (stat.scan_done)
                begin
                    emit_reg <= lo_reg;
                    mv_reg   <= ins ? fill_reg - CW'(1) : hi_reg;
                    mph_reg  <= (ins && fill_reg == hi_reg) ? MPH_NEW : MPH_READ;
                end
            end
            if (cmd.move_step)
            begin
                if (ins)
                begin
                    if (mph_reg == MPH_READ)
                    begin
                        mph_reg <= MPH_WRITE;
                    end
                    else if (mph_reg == MPH_WRITE)
                    begin
                        if (mv_reg == hi_reg)
                        begin
                            mph_reg <= MPH_NEW;
                        end
                        else
                        begin
                            mph_reg <= MPH_READ;
                            mv_reg  <= mv_reg - CW'(1);
                        end
                    end
                end
                else
                begin
                    if (mph_reg == MPH_READ)
                    begin
                        if (mv_reg < fill_reg)
                        begin
                            mph_reg <= MPH_WRITE;
                        end
                    end
                    else
                    begin
                        mph_reg <= MPH_READ;
                        mv_reg  <= mv_reg + CW'(1);
                    end
                end
            end
            if (cmd.emit_step)
            begin
                emit_reg <= emit_plus;
            end
            if (cmd.fill_upd)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.play_upd)
            begin
                play_reg <= pl_next_reg;
            end
        end
    end

    always_comb
    begin
        case (c_reg) inside
            CMD_ADD:
                fill_next = fill_reg + CW'(1);
            CMD_CLEAR:
                fill_next = '0;
            CMD_REMOVE_AT, CMD_REMOVE_RG, CMD_ADVANCE:
                fill_next = fill_reg - (hi_reg - lo_reg);
            default:
                fill_next = fill_reg;
        endcase
    end
endmodule

>>> sv/timed_cue_table.sv
// timed_cue_table: a time-sorted table of cues with a Q16.16 playhead.
// Requests arrive on the in channel (command, time_a, time_b, cue_id); the
// block takes one request at a time and accepts the next one only after the
// last result of the current one has been taken and its table update is done.
// Every request yields one or more results; last marks the final one.
// Advance and query stream one result per matched cue in time order, at most
// MAX_RESULTS, or a single acknowledgement when nothing matches.
// Each request is accepted, then the table is scanned one entry per cycle;
// each reported cue is read from the cue memory and then presented, and an
// insert or an erase sweeps each shifted entry with a read and then a write;
// an acknowledgement is given when no cue is reported.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset clears the fill count, the playhead and auto_remove; the cue memory
// needs no clearing because only entries below the fill count are read.
// auto_remove is at APB address 0.
module timed_cue_table import tct_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tct_in_if.sink      req,
    tct_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] ADDR_AUTO_REMOVE = 2'(4 * REG_AUTO_REMOVE);

    logic auto_remove_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic full, rev_range;
    logic [ID_W-1:0] hid;
    logic signed [DATA_W-1:0] htime;
    logic ohit;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_AUTO_REMOVE) ? {31'd0, auto_remove_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_remove_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_AUTO_REMOVE)
        begin
            auto_remove_reg <= pwdata[0];
        end
    end

    tct_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
        .in_cmd(req.command), .auto_remove(auto_remove_reg), .full(full),
        .rev_range(rev_range), .out_ready(rsp.ready), .out_valid(rsp.valid),
        .out_hit(ohit), .out_status(rsp.status), .out_last(rsp.last),
        .cmd(cmd), .stat(stat));

    tct_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_cmd(req.command), .in_a(req.time_a),
        .in_b(req.time_b), .in_id(req.cue_id),
        .cmd(cmd), .stat(stat), .full(full), .rev_range(rev_range),
        .hit_id(hid), .hit_time(htime));

    assign rsp.hit = ohit;
    assign rsp.hit_id = ohit ? hid : 8'd0;
    assign rsp.hit_time = ohit ? htime : 32'sd0;
endmodule

>>> sv/tct_checker.sv
module tct_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_hit,
    input logic out_status,
    input logic out_last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while results pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken without a gap");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> !out_hit && out_last)
        else $error("full status on a hit");
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_last)
        else $error("acknowledgement not last");
endmodule

bind timed_cue_table tct_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_hit(rsp.hit),
    .out_status(rsp.status), .out_last(rsp.last));
